// ----- design/lfcv_pkg.sv -----
// Package for the lagged follow camera view block.
// Holds the request and result structs, fixed-point constants and rounding helpers.
// No dependencies.
package lfcv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q14_BITS  = 14;
    localparam int RATE_BITS = 16;
    localparam int POS_W     = 32;
    localparam int BAS_W     = 16;
    localparam int RATE_W    = 17;
    localparam int ACC_W     = 64;
    localparam int VEC_W     = 40;
    localparam int NORM_BIT  = 30;
    localparam int MUL_STEPS = 32;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [ACC_W-1:0] LOOK_K = 64'sd1000 <<< FRAC_BITS;
    localparam logic [RATE_W-1:0] RATE_ONE   = 17'd65536;
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd16384;
    localparam logic signed [BAS_W-1:0] ONE_Q14 = 16'sd16384;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_RATE = 2'd3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [15:0] look_x;
        logic signed [15:0] look_y;
        logic signed [15:0] look_z;
    } in_t;

    typedef struct packed {
        logic [2:0]         row_index;
        logic signed [31:0] col_a;
        logic signed [31:0] col_b;
        logic signed [31:0] col_c;
        logic               last_row;
    } out_t;

    // Rounds to nearest with halves away from zero, dropping k low bits.
    function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] v,
                                                          input int k);
        logic [ACC_W-1:0] m;
        m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        m = (m + (64'd1 << (k - 1))) >> k;
        return v[ACC_W-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
        return POS_W'(v);
    endfunction

    function automatic logic signed [BAS_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        if (v > 64'sd32767) return 16'sh7FFF;
        if (v < -64'sd32768) return 16'sh8000;
        return BAS_W'(v);
    endfunction

    function automatic logic signed [POS_W-1:0] q14_to_pos(input logic signed [BAS_W-1:0] v);
        logic signed [ACC_W-1:0] p;
        p = ACC_W'(v) <<< FRAC_BITS;
        return sat32(rnd_shift(p, Q14_BITS));
    endfunction

    function automatic logic [1:0] idx3(input logic [2:0] v);
        case (v)
            3'd0: return 2'd0;
            3'd1: return 2'd1;
            3'd2: return 2'd2;
            3'd3: return 2'd0;
            3'd4: return 2'd1;
            3'd5: return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

endpackage

// ----- design/lagged_follow_camera_view.sv -----
// Lagged follow camera: eye smoothing and left-handed look-at view rows.
// Shared bit-serial multiplier, bit-serial square root and divider, one sequencer.
// Depends on lfcv_pkg.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_data (in_t), one frame tick
//  m_      | out       | m_valid / m_ready  | m_data (out_t), five rows per tick
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Every product runs through one shift-add multiplier, one multiplier bit a cycle. A
// tick with a still eye takes 18 products; a moving eye takes 42 products plus two
// 32-step square roots and six 16-step divides. Then five rows leave, one per accepted
// result.
// A new request is taken only after the last row is accepted; reset is synchronous.
module lagged_follow_camera_view (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lfcv_pkg::in_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lfcv_pkg::out_t   m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  lfcv_pkg::cfg_idx_t cfg_index,
    input  logic [31:0]      cfg_data
);
    import lfcv_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_LOAD    = 4'd1;
    localparam logic [3:0] ST_MAC     = 4'd2;
    localparam logic [3:0] ST_WB      = 4'd3;
    localparam logic [3:0] ST_MOVE    = 4'd4;
    localparam logic [3:0] ST_NMAG    = 4'd5;
    localparam logic [3:0] ST_NSHIFT  = 4'd6;
    localparam logic [3:0] ST_SQRT    = 4'd7;
    localparam logic [3:0] ST_DIVINIT = 4'd8;
    localparam logic [3:0] ST_DIV     = 4'd9;
    localparam logic [3:0] ST_OUT     = 4'd10;

    localparam logic [2:0] PH_DES = 3'd0;
    localparam logic [2:0] PH_EYE = 3'd1;
    localparam logic [2:0] PH_AT  = 3'd2;
    localparam logic [2:0] PH_SQ  = 3'd3;
    localparam logic [2:0] PH_CRS = 3'd4;
    localparam logic [2:0] PH_Y   = 3'd5;
    localparam logic [2:0] PH_TRN = 3'd6;

    localparam logic [2:0] ROW_TRN = 3'd3;
    localparam logic [2:0] ROW_EYE = 3'd4;

    logic [3:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [1:0] lane_reg, lane_next;
    logic [1:0] term_reg, term_next;
    logic       nsel_reg, nsel_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] row_reg, row_next;

    logic signed [POS_W-1:0] off_reg [3];
    logic signed [POS_W-1:0] off_next [3];
    logic [RATE_W-1:0]       rate_reg, rate_next;
    logic signed [POS_W-1:0] eye_reg [3];
    logic signed [POS_W-1:0] eye_next [3];
    logic signed [BAS_W-1:0] basis_reg [9];
    logic signed [BAS_W-1:0] basis_next [9];

    in_t                     in_reg, in_next;
    logic signed [POS_W-1:0] desired_reg [3];
    logic signed [POS_W-1:0] desired_next [3];
    logic signed [POS_W-1:0] trans_reg [3];
    logic signed [POS_W-1:0] trans_next [3];
    logic signed [VEC_W-1:0] vec_reg [3];
    logic signed [VEC_W-1:0] vec_next [3];
    logic [VEC_W-1:0]        mag_reg [3];
    logic [VEC_W-1:0]        mag_next [3];
    logic [2:0]              neg_reg, neg_next;
    logic signed [BAS_W-1:0] zb_reg [3];
    logic signed [BAS_W-1:0] zb_next [3];
    logic signed [BAS_W-1:0] xb_reg [3];
    logic signed [BAS_W-1:0] xb_next [3];
    logic signed [BAS_W-1:0] yb_reg [3];
    logic signed [BAS_W-1:0] yb_next [3];
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] ma_reg, ma_next;
    logic [31:0]             mb_reg, mb_next;
    logic                    sub_reg, sub_next;
    logic [ACC_W-1:0]        sqx_reg, sqx_next;
    logic [ACC_W-1:0]        sqr_reg, sqr_next;
    logic [ACC_W-1:0]        sqb_reg, sqb_next;
    logic [31:0]             len_reg, len_next;
    logic [31:0]             rem_reg, rem_next;
    logic [15:0]             nlo_reg, nlo_next;
    logic [15:0]             q_reg, q_next;

    logic signed [BAS_W-1:0] in_vec [3][3];
    logic signed [POS_W-1:0] tgt [3];
    logic signed [ACC_W-1:0] op_a;
    logic [31:0]             op_b;
    logic                    op_sub;
    logic [1:0]              term_last;
    logic [1:0]              ia, ib;
    logic [3:0]              bidx;
    logic                    moving;

    always_comb begin
        tgt[0] = in_reg.target_x;
        tgt[1] = in_reg.target_y;
        tgt[2] = in_reg.target_z;
        in_vec[0][0] = in_reg.right_x;
        in_vec[0][1] = in_reg.right_y;
        in_vec[0][2] = in_reg.right_z;
        in_vec[1][0] = in_reg.up_x;
        in_vec[1][1] = in_reg.up_y;
        in_vec[1][2] = in_reg.up_z;
        in_vec[2][0] = in_reg.look_x;
        in_vec[2][1] = in_reg.look_y;
        in_vec[2][2] = in_reg.look_z;
    end

    assign ia   = idx3(3'(lane_reg) + 3'd1 + 3'(term_reg));
    assign ib   = idx3(3'(lane_reg) + 3'd2 - 3'(term_reg));
    assign bidx = {1'b0, lane_reg, 1'b0} + 4'(lane_reg) + 4'(term_reg);

    assign moving = (rate_reg != '0) && ((desired_reg[0] != eye_reg[0]) ||
                    (desired_reg[1] != eye_reg[1]) || (desired_reg[2] != eye_reg[2]));

    // Operand selection for the shared multiplier.
    always_comb begin
        op_a      = '0;
        op_b      = '0;
        op_sub    = 1'b0;
        term_last = 2'd0;
        case (phase_reg)
            PH_DES: begin
                op_a      = ACC_W'(off_reg[term_reg]);
                op_b      = 32'(in_vec[term_reg][lane_reg]);
                term_last = 2'd2;
            end
            PH_EYE: begin
                op_a = ACC_W'(desired_reg[lane_reg]) - ACC_W'(eye_reg[lane_reg]);
                op_b = 32'(rate_reg);
            end
            PH_AT: begin
                op_a = LOOK_K;
                op_b = 32'(in_vec[2][lane_reg]);
            end
            PH_SQ: begin
                op_a      = ACC_W'(mag_reg[term_reg][NORM_BIT-1:0]);
                op_b      = 32'(mag_reg[term_reg][NORM_BIT-1:0]);
                term_last = 2'd2;
            end
            PH_CRS: begin
                op_a      = ACC_W'(in_vec[1][ia]);
                op_b      = 32'(zb_reg[ib]);
                op_sub    = term_reg[0];
                term_last = 2'd1;
            end
            PH_Y: begin
                op_a      = ACC_W'(zb_reg[ia]);
                op_b      = 32'(xb_reg[ib]);
                op_sub    = term_reg[0];
                term_last = 2'd1;
            end
            PH_TRN: begin
                op_a      = ACC_W'(eye_reg[term_reg]);
                op_b      = 32'(basis_reg[bidx]);
                term_last = 2'd2;
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    always_comb begin
        logic signed [ACC_W-1:0] addend;
        logic [ACC_W-1:0]        sq_t;
        logic [ACC_W-1:0]        sq_r;
        logic [45:0]             num;
        logic [32:0]             dv_t;
        logic                    ge;
        logic [15:0]             qn;
        logic signed [BAS_W-1:0] res;
        logic                    any_big;
        logic                    all_zero;

        state_next = state_reg;
        phase_next = phase_reg;
        lane_next  = lane_reg;
        term_next  = term_reg;
        nsel_next  = nsel_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        off_next   = off_reg;
        rate_next  = rate_reg;
        eye_next   = eye_reg;
        basis_next = basis_reg;
        in_next    = in_reg;
        desired_next = desired_reg;
        trans_next = trans_reg;
        vec_next   = vec_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        zb_next    = zb_reg;
        xb_next    = xb_reg;
        yb_next    = yb_reg;
        acc_next   = acc_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        sub_next   = sub_reg;
        sqx_next   = sqx_reg;
        sqr_next   = sqr_reg;
        sqb_next   = sqb_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        nlo_next   = nlo_reg;
        q_next     = q_reg;
        addend     = '0;
        sq_t       = '0;
        sq_r       = '0;
        num        = '0;
        dv_t       = '0;
        ge         = 1'b0;
        qn         = '0;
        res        = '0;
        any_big    = 1'b0;
        all_zero   = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_OFFSET_X: off_next[0] = cfg_data;
                CFG_OFFSET_Y: off_next[1] = cfg_data;
                CFG_OFFSET_Z: off_next[2] = cfg_data;
                CFG_FOLLOW_RATE: rate_next = (cfg_data[RATE_W-1:0] > RATE_ONE) ?
                                             RATE_ONE : cfg_data[RATE_W-1:0];
                default: rate_next = rate_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    phase_next = PH_DES;
                    lane_next  = 2'd0;
                    term_next  = 2'd0;
                    acc_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                ma_next    = op_a;
                mb_next    = op_b;
                sub_next   = op_sub;
                cnt_next   = '0;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                addend = mb_reg[0] ? ma_reg : '0;
                if (sub_reg ^ (cnt_reg == 5'(MUL_STEPS - 1))) begin
                    acc_next = acc_reg - addend;
                end else begin
                    acc_next = acc_reg + addend;
                end
                ma_next  = ma_reg <<< 1;
                mb_next  = mb_reg >> 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(MUL_STEPS - 1)) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                if (term_reg != term_last) begin
                    term_next  = term_reg + 2'd1;
                    state_next = ST_LOAD;
                end else begin
                    term_next  = 2'd0;
                    acc_next   = '0;
                    state_next = ST_LOAD;
                    lane_next  = lane_reg + 2'd1;
                    case (phase_reg)
                        PH_DES: begin
                            desired_next[lane_reg] = sat32(ACC_W'(tgt[lane_reg]) +
                                                           rnd_shift(acc_reg, Q14_BITS));
                            if (lane_reg == 2'd2) begin
                                lane_next  = 2'd0;
                                state_next = ST_MOVE;
                            end
                        end
                        PH_EYE: begin
                            eye_next[lane_reg] = sat32(ACC_W'(eye_reg[lane_reg]) +
                                                       rnd_shift(acc_reg, RATE_BITS));
                            if (lane_reg == 2'd2) begin
                                lane_next  = 2'd0;
                                phase_next = PH_AT;
                            end
                        end
                        PH_AT: begin
                            vec_next[lane_reg] = VEC_W'(ACC_W'(tgt[lane_reg]) +
                                rnd_shift(acc_reg, Q14_BITS) - ACC_W'(eye_reg[lane_reg]));
                            if (lane_reg == 2'd2) begin
                                lane_next  = 2'd0;
                                nsel_next  = 1'b0;
                                state_next = ST_NMAG;
                            end
                        end
                        PH_SQ: begin
                            lane_next  = 2'd0;
                            sqx_next   = acc_reg;
                            sqr_next   = '0;
                            sqb_next   = 64'd1 << (2 * (SQRT_STEPS - 1));
                            cnt_next   = '0;
                            state_next = ST_SQRT;
                        end
                        PH_CRS: begin
                            vec_next[lane_reg] = VEC_W'(acc_reg);
                            if (lane_reg == 2'd2) begin
                                lane_next  = 2'd0;
                                nsel_next  = 1'b1;
                                state_next = ST_NMAG;
                            end
                        end
                        PH_Y: begin
                            yb_next[lane_reg] = sat16(rnd_shift(acc_reg, Q14_BITS));
                            if (lane_reg == 2'd2) begin
                                basis_next[0] = xb_reg[0];
                                basis_next[1] = xb_reg[1];
                                basis_next[2] = xb_reg[2];
                                basis_next[3] = yb_reg[0];
                                basis_next[4] = yb_reg[1];
                                basis_next[5] = sat16(rnd_shift(acc_reg, Q14_BITS));
                                basis_next[6] = zb_reg[0];
                                basis_next[7] = zb_reg[1];
                                basis_next[8] = zb_reg[2];
                                lane_next     = 2'd0;
                                phase_next    = PH_TRN;
                            end
                        end
                        PH_TRN: begin
                            trans_next[lane_reg] = sat32(-rnd_shift(acc_reg, Q14_BITS));
                            if (lane_reg == 2'd2) begin
                                lane_next  = 2'd0;
                                row_next   = '0;
                                state_next = ST_OUT;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MOVE: begin
                phase_next = moving ? PH_EYE : PH_TRN;
                state_next = ST_LOAD;
            end
            ST_NMAG: begin
                all_zero = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    neg_next[i] = vec_reg[i][VEC_W-1];
                    mag_next[i] = vec_reg[i][VEC_W-1] ? VEC_W'(-vec_reg[i]) : VEC_W'(vec_reg[i]);
                    if (vec_reg[i] != '0) all_zero = 1'b0;
                end
                if (all_zero) begin
                    phase_next = PH_TRN;
                    state_next = ST_LOAD;
                end else begin
                    state_next = ST_NSHIFT;
                end
            end
            ST_NSHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    if (|mag_reg[i][VEC_W-1:NORM_BIT]) any_big = 1'b1;
                end
                if (any_big) begin
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] >> 1;
                end else begin
                    phase_next = PH_SQ;
                    term_next  = 2'd0;
                    state_next = ST_LOAD;
                end
            end
            ST_SQRT: begin
                sq_t = sqr_reg + sqb_reg;
                if (sqx_reg >= sq_t) begin
                    sqx_next = sqx_reg - sq_t;
                    sq_r     = (sqr_reg >> 1) + sqb_reg;
                end else begin
                    sq_r = sqr_reg >> 1;
                end
                sqr_next = sq_r;
                sqb_next = sqb_reg >> 2;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQRT_STEPS - 1)) begin
                    len_next   = sq_r[31:0];
                    lane_next  = 2'd0;
                    state_next = ST_DIVINIT;
                end
            end
            ST_DIVINIT: begin
                num        = {2'b00, mag_reg[lane_reg][NORM_BIT-1:0], 14'd0} +
                             46'(len_reg >> 1);
                rem_next   = 32'(num[45:16]);
                nlo_next   = num[15:0];
                q_next     = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                dv_t     = {rem_reg, nlo_reg[15]};
                ge       = dv_t >= {1'b0, len_reg};
                rem_next = ge ? 32'(dv_t - {1'b0, len_reg}) : dv_t[31:0];
                qn       = {q_reg[14:0], ge};
                q_next   = qn;
                nlo_next = nlo_reg << 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    res = sat16(neg_reg[lane_reg] ? -ACC_W'(qn) : ACC_W'(qn));
                    if (nsel_reg) begin
                        xb_next[lane_reg] = res;
                    end else begin
                        zb_next[lane_reg] = res;
                    end
                    if (lane_reg == 2'd2) begin
                        lane_next  = 2'd0;
                        term_next  = 2'd0;
                        acc_next   = '0;
                        phase_next = nsel_reg ? PH_Y : PH_CRS;
                        state_next = ST_LOAD;
                    end else begin
                        lane_next  = lane_reg + 2'd1;
                        state_next = ST_DIVINIT;
                    end
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    row_next = row_reg + 3'd1;
                    if (row_reg == ROW_EYE) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_DES;
            lane_reg  <= '0;
            term_reg  <= '0;
            nsel_reg  <= 1'b0;
            cnt_reg   <= '0;
            row_reg   <= '0;
            rate_reg  <= RATE_RESET;
            for (int i = 0; i < 3; i++) begin
                off_reg[i] <= '0;
                eye_reg[i] <= '0;
            end
            for (int i = 0; i < 9; i++) begin
                basis_reg[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q14 : '0;
            end
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            lane_reg  <= lane_next;
            term_reg  <= term_next;
            nsel_reg  <= nsel_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            rate_reg  <= rate_next;
            off_reg   <= off_next;
            eye_reg   <= eye_next;
            basis_reg <= basis_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg      <= in_next;
        desired_reg <= desired_next;
        trans_reg   <= trans_next;
        vec_reg     <= vec_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        zb_reg      <= zb_next;
        xb_reg      <= xb_next;
        yb_reg      <= yb_next;
        acc_reg     <= acc_next;
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        sub_reg     <= sub_next;
        sqx_reg     <= sqx_next;
        sqr_reg     <= sqr_next;
        sqb_reg     <= sqb_next;
        len_reg     <= len_next;
        rem_reg     <= rem_next;
        nlo_reg     <= nlo_next;
        q_reg       <= q_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign cfg_ready = 1'b1;

    always_comb begin
        m_data.row_index = row_reg;
        m_data.last_row  = (row_reg == ROW_EYE);
        case (row_reg)
            ROW_TRN: begin
                m_data.col_a = trans_reg[0];
                m_data.col_b = trans_reg[1];
                m_data.col_c = trans_reg[2];
            end
            ROW_EYE: begin
                m_data.col_a = eye_reg[0];
                m_data.col_b = eye_reg[1];
                m_data.col_c = eye_reg[2];
            end
            default: begin
                m_data.col_a = q14_to_pos(basis_reg[4'(row_reg)]);
                m_data.col_b = q14_to_pos(basis_reg[4'(row_reg) + 4'd3]);
                m_data.col_c = q14_to_pos(basis_reg[4'(row_reg) + 4'd6]);
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while rows are pending");

    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready && !m_valid)
        else $error("request not held in the sequencer");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_row) |=> s_ready)
        else $error("block not idle after the last row");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.row_index <= ROW_EYE))
        else $error("row index out of range");
`endif

endmodule
